// ===== design/etbu_pkg.sv =====
// ----------------------------------------------------------------------------
// etbu_pkg
// shared widths, codes and types of the elimination tree builder
// ----------------------------------------------------------------------------
package etbu_pkg;

   localparam int IDX_W         = 10;
   localparam int LINK_W        = IDX_W + 1;
   localparam int MAX_NODES_DEF = 1024;

   // input word modes
   localparam logic [1:0] MODE_BEGIN = 2'd0;
   localparam logic [1:0] MODE_ENTRY = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // result word kinds
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // one stored link: valid flag and node index
   typedef struct packed {
      logic             ok;
      logic [IDX_W-1:0] idx;
   } link_type;

   // one result word
   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] child;
      logic [IDX_W-1:0] parent;
      logic             has_parent;
   } res_type;

   // one memory command, addressed by node index
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      link_type         wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
   } mem_cmd_type;

endpackage

// ===== design/etbu_if.sv =====
// ----------------------------------------------------------------------------
// etbu_req_if / etbu_rsp_if
// valid/ready channels carrying request and response words
// ----------------------------------------------------------------------------
interface etbu_req_if;
   import etbu_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       mode;
   logic [IDX_W-1:0] row;
   logic [IDX_W-1:0] col;

   modport source (output valid, output mode, output row, output col, input ready);
   modport sink   (input valid, input mode, input row, input col, output ready);
endinterface

interface etbu_rsp_if;
   import etbu_pkg::*;

   logic             valid;
   logic             ready;
   logic             kind;
   logic [IDX_W-1:0] child;
   logic [IDX_W-1:0] parent;
   logic             has_parent;

   modport source (output valid, output kind, output child, output parent,
                   output has_parent, input ready);
   modport sink   (input valid, input kind, input child, input parent,
                   input has_parent, output ready);
endinterface

// ===== design/etbu_ram.sv =====
// ----------------------------------------------------------------------------
// etbu_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module etbu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/etbu_seq.sv =====
// ----------------------------------------------------------------------------
// etbu_seq
// sequencer for row begin, ancestor walk with path compression, parent read
// ----------------------------------------------------------------------------
module etbu_seq #(
   parameter int MAX_NODES = etbu_pkg::MAX_NODES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_mode,
   input  logic [etbu_pkg::IDX_W-1:0] req_row,
   input  logic [etbu_pkg::IDX_W-1:0] req_col,
   output etbu_pkg::mem_cmd_type     anc_cmd,
   input  etbu_pkg::link_type        anc_rd,
   output etbu_pkg::mem_cmd_type     par_cmd,
   input  etbu_pkg::link_type        par_rd,
   output logic                      res_valid,
   output etbu_pkg::res_type         res,
   input  logic                      res_take
);
   import etbu_pkg::*;

   localparam int STEP_W = $clog2(MAX_NODES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_PAR,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cur_row_ff, cur_row_in;
   logic [IDX_W-1:0]  node_ff, node_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   res_type           res_ff, res_in;
   logic              accept;

   function automatic logic in_range(input logic [IDX_W-1:0] i);
      return 32'(i) < MAX_NODES;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == ST_EMIT);
   assign res       = res_ff;

   always_comb begin
      state_in   = state_ff;
      cur_row_in = cur_row_ff;
      node_in    = node_ff;
      steps_in   = steps_ff;
      res_in     = res_ff;
      anc_cmd    = '0;
      par_cmd    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_BEGIN: begin
                     cur_row_in = req_row;
                     if (in_range(req_row)) begin
                        anc_cmd.wr_en   = 1'b1;
                        anc_cmd.wr_idx  = req_row;
                        anc_cmd.wr_data = '0;
                        par_cmd.wr_en   = 1'b1;
                        par_cmd.wr_idx  = req_row;
                        par_cmd.wr_data = '0;
                     end
                  end
                  MODE_ENTRY: begin
                     // a column at or above the row walks nothing
                     if ((req_col < cur_row_ff) && in_range(req_col)) begin
                        anc_cmd.rd_en  = 1'b1;
                        anc_cmd.rd_idx = req_col;
                        node_in        = req_col;
                        steps_in       = '0;
                        state_in       = ST_WALK;
                     end
                  end
                  MODE_READ: begin
                     if (in_range(req_col)) begin
                        par_cmd.rd_en  = 1'b1;
                        par_cmd.rd_idx = req_col;
                        node_in        = req_col;
                        state_in       = ST_PAR;
                     end else begin
                        res_in   = '{kind: KIND_READ, child: req_col, parent: '0,
                                     has_parent: 1'b0};
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // path compression: every visited node now points at the row
            anc_cmd.wr_en   = 1'b1;
            anc_cmd.wr_idx  = node_ff;
            anc_cmd.wr_data = '{ok: 1'b1, idx: cur_row_ff};
            steps_in        = steps_ff + STEP_W'(1);
            if (!anc_rd.ok) begin
               par_cmd.wr_en   = 1'b1;
               par_cmd.wr_idx  = node_ff;
               par_cmd.wr_data = '{ok: 1'b1, idx: cur_row_ff};
               res_in   = '{kind: KIND_EDGE, child: node_ff, parent: cur_row_ff,
                            has_parent: 1'b1};
               state_in = ST_EMIT;
            end else if ((anc_rd.idx < cur_row_ff) && in_range(anc_rd.idx)
                         && (32'(steps_in) < MAX_NODES)) begin
               anc_cmd.rd_en  = 1'b1;
               anc_cmd.rd_idx = anc_rd.idx;
               node_in        = anc_rd.idx;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAR: begin
            res_in   = '{kind: KIND_READ, child: node_ff,
                         parent: par_rd.ok ? par_rd.idx : '0,
                         has_parent: par_rd.ok};
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         cur_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cur_row_ff <= cur_row_in;
      end
   end

   // a walked node always lies below the current row
   a_walk_below_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (node_ff < cur_row_ff))
      else $error("walk visits a node not below the current row");

   // the step count never reaches the node count inside a walk
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (32'(steps_ff) < MAX_NODES))
      else $error("walk exceeds step bound");

   // a pending result holds until taken
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !res_take) |=> (state_ff == ST_EMIT && $stable(res_ff)))
      else $error("pending result lost or changed");

   // a tree edge always names the current row as parent
   a_edge_parent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && res_ff.kind == KIND_EDGE)
         |-> (res_ff.has_parent && res_ff.parent == cur_row_ff))
      else $error("tree edge with wrong parent");

   // no word is taken while a walk or read is in flight
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK || state_ff == ST_PAR) |-> !req_ready)
      else $error("ready raised while busy");

endmodule

// ===== design/elimination_tree_builder_unit.sv =====
// ----------------------------------------------------------------------------
// elimination_tree_builder_unit
// elimination tree construction with path-compressed ancestor links
// ----------------------------------------------------------------------------
// Builds the elimination tree of a symmetric sparse matrix from its lower
// triangle, fed row by row in ascending order. A begin word (mode 0) opens a
// row and marks it parentless. An entry word (mode 1) walks
// the ancestor chain from its column through the ancestor ram, one node per
// cycle, pointing every visited node at the row; a walk that ends on a root
// reports a new tree edge. A read word (mode 2) returns one node's parent.
// The walk rate is set by the single read port of the ancestor ram, which
// has registered read data. Words are taken only while no walk or read is in
// progress; a finished result sits in the output register while the next
// word is already accepted. The link rams have no reset: a node must be begun
// before it is walked or read.
// ----------------------------------------------------------------------------
module elimination_tree_builder_unit #(
   parameter int MAX_NODES = etbu_pkg::MAX_NODES_DEF
) (
   input logic        clock,
   input logic        reset,
   etbu_req_if.sink   req_ch,
   etbu_rsp_if.source rsp_ch
);
   import etbu_pkg::*;

   localparam int ADDR_W = $clog2(MAX_NODES);

   // sequencer to ram commands and read data
   mem_cmd_type anc_cmd, par_cmd;
   link_type    anc_rd, par_rd;

   // sequencer result hand-off
   logic        seq_res_valid;
   res_type     seq_res;
   logic        res_take;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     rsp_data_ff;

   etbu_seq #(
      .MAX_NODES (MAX_NODES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_mode  (req_ch.mode),
      .req_row   (req_ch.row),
      .req_col   (req_ch.col),
      .anc_cmd   (anc_cmd),
      .anc_rd    (anc_rd),
      .par_cmd   (par_cmd),
      .par_rd    (par_rd),
      .res_valid (seq_res_valid),
      .res       (seq_res),
      .res_take  (res_take)
   );

   // ancestor links: valid flag plus ancestor node
   etbu_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_NODES)
   ) u_anc_ram (
      .clock   (clock),
      .wr_en   (anc_cmd.wr_en),
      .wr_addr (ADDR_W'(anc_cmd.wr_idx)),
      .wr_data (anc_cmd.wr_data),
      .rd_en   (anc_cmd.rd_en),
      .rd_addr (ADDR_W'(anc_cmd.rd_idx)),
      .rd_data (anc_rd)
   );

   // parent links: valid flag plus parent node
   etbu_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_NODES)
   ) u_par_ram (
      .clock   (clock),
      .wr_en   (par_cmd.wr_en),
      .wr_addr (ADDR_W'(par_cmd.wr_idx)),
      .wr_data (par_cmd.wr_data),
      .rd_en   (par_cmd.rd_en),
      .rd_addr (ADDR_W'(par_cmd.rd_idx)),
      .rd_data (par_rd)
   );

   // output register loads when empty or drained in the same cycle
   assign res_take = seq_res_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= seq_res;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_data_ff.kind;
   assign rsp_ch.child      = rsp_data_ff.child;
   assign rsp_ch.parent     = rsp_data_ff.parent;
   assign rsp_ch.has_parent = rsp_data_ff.has_parent;

endmodule

// ===== sim/tb_elimination_tree_builder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elimination_tree_builder_unit
// self-checking bench for the elimination tree builder
// ----------------------------------------------------------------------------
// Feeds begin, entry and read words to the block and predicts every tree edge
// and parent reply with a path-compressed tree model of its own. A directed
// opening covers roots, diagonal entries, compressed walks, ignored words and
// the top index; random sparse patterns with short runs of noise follow.
// Both channels idle at random, the receiver holds off once for a long
// stretch, and a watchdog ends a run in which no word moves.
// ----------------------------------------------------------------------------
module tb_elimination_tree_builder_unit;
   import etbu_pkg::*;

   // the one mode the block ignores
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   localparam int NODES       = MAX_NODES_DEF;
   localparam int IDLE_LIMIT  = 20000;  // cycles with no word moving on either side
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int TAIL_CYCLES = 1100;   // longest possible walk plus margin

   // -------------------------------------------------------------------------
   // tree model and store of expected result words
   // -------------------------------------------------------------------------
   class etree_scoreboard;
      link_type         parent_of[NODES];
      link_type         ancestor_of[NODES];
      logic [IDX_W-1:0] open_row;
      res_type          awaited_words[$];
      int               fail_count;
      int               rows_begun;
      int               entries_seen;
      int               reads_seen;
      int               edges_checked;
      int               replies_checked;

      function new();
         open_row = '0;
      endfunction

      function int pending();
         return awaited_words.size();
      endfunction

      // advance the tree by one accepted word, queue the word it must produce
      function void note_word(logic [1:0] mode, logic [IDX_W-1:0] row,
                              logic [IDX_W-1:0] col);
         int       node;
         int       steps;
         link_type prior;
         res_type  want;
         want = '0;
         case (mode)
            MODE_BEGIN: begin
               open_row         = row;
               parent_of[row]   = '0;  // no parent
               ancestor_of[row] = '0;  // no ancestor
               rows_begun++;
            end
            MODE_ENTRY: begin
               entries_seen++;
               node  = int'(col);
               steps = 0;
               // climb the ancestor chain, pointing every node at the open row
               while (node < open_row && steps < NODES) begin
                  prior             = ancestor_of[node];
                  ancestor_of[node] = {1'b1, open_row};
                  steps++;
                  if (!prior.ok) begin
                     // chain top reached: new tree edge
                     parent_of[node] = {1'b1, open_row};
                     want.kind       = KIND_EDGE;
                     want.child      = node[IDX_W-1:0];
                     want.parent     = open_row;
                     want.has_parent = 1'b1;
                     awaited_words.push_back(want);
                     break;
                  end
                  node = int'(prior.idx);
               end
            end
            MODE_READ: begin
               reads_seen++;
               want.kind       = KIND_READ;
               want.child      = col;
               want.has_parent = parent_of[col].ok;
               want.parent     = parent_of[col].ok ? parent_of[col].idx : '0;
               awaited_words.push_back(want);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [IDX_W-1:0] want,
                                  logic [IDX_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_word(res_type got);
         res_type want;
         if (awaited_words.size() == 0) begin
            $error("unexpected result word: kind %0d child %0d parent %0d has_parent %0d",
                   got.kind, got.child, got.parent, got.has_parent);
            fail_count++;
            return;
         end
         want = awaited_words.pop_front();
         compare_field("kind", IDX_W'(want.kind), IDX_W'(got.kind));
         compare_field("child", want.child, got.child);
         compare_field("parent", want.parent, got.parent);
         compare_field("has_parent", IDX_W'(want.has_parent), IDX_W'(got.has_parent));
         if (want.kind == KIND_EDGE)
            edges_checked++;
         else
            replies_checked++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   etbu_req_if req_bus ();
   etbu_rsp_if rsp_bus ();

   elimination_tree_builder_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #5 clock = ~clock;

   etree_scoreboard  tree_sb;
   bit               begun[NODES];     // nodes whose links have been written
   logic [IDX_W-1:0] cur_row = '0;     // row opened by the last begin word
   bit               idle_on = 1'b1;   // random gaps on both sides
   bit               hold_req = 1'b0;  // asks the receiver for one long hold-off
   int               holds_done = 0;
   int               words_sent = 0;   // words the block acts on
   int               idle_cycles = 0;

   // gap length shared by sender and receiver: mostly none, a few long
   function automatic int idle_length();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(12, 48);
   endfunction

   // random node below limit whose links exist, -1 when none turns up
   function automatic int find_begun(int limit);
      int pick;
      if (limit <= 0)
         return -1;
      repeat (12) begin
         pick = $urandom_range(0, limit - 1);
         if (begun[pick])
            return pick;
      end
      return -1;
   endfunction

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   // offer one word at the falling edge, hold it until taken, then maybe idle
   task automatic send_word(input logic [1:0] mode, input int row, input int col);
      int gap;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.mode  <= mode;
      req_bus.row   <= IDX_W'(row);
      req_bus.col   <= IDX_W'(col);
      do @(posedge clock); while (!req_bus.ready);
      tree_sb.note_word(mode, IDX_W'(row), IDX_W'(col));
      if (mode == MODE_BEGIN) begin
         begun[row] = 1'b1;
         cur_row    = IDX_W'(row);
      end
      if (mode != MODE_IGNORED)
         words_sent++;
      gap = idle_length();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // read back a node that has been begun; row field is junk
   task automatic send_read();
      int node;
      node = find_begun(NODES);
      if (node < 0)
         node = int'(cur_row);
      send_word(MODE_READ, $urandom_range(0, NODES - 1), node);
   endtask

   // one lower-triangle pattern on consecutive rows from a random base
   task automatic send_matrix(int size);
      int base;
      int r;
      int k;
      int fill;
      int sel;
      int col_pick;
      base = $urandom_range(0, NODES - size);
      for (r = 0; r < size; r++) begin
         send_word(MODE_BEGIN, base + r, $urandom_range(0, NODES - 1));
         fill = $urandom_range(0, (r < 5) ? r : 5);
         for (k = 0; k < fill; k++) begin
            sel      = $urandom_range(0, 99);
            col_pick = -1;
            if (sel < 85)
               col_pick = base + $urandom_range(0, r - 1);
            else if (sel < 95)
               col_pick = find_begun(base + r);  // reach into older trees
            // on or above the diagonal: no walk
            if (col_pick < 0)
               col_pick = $urandom_range(base + r, NODES - 1);
            send_word(MODE_ENTRY, $urandom_range(0, NODES - 1), col_pick);
         end
         if ($urandom_range(0, 9) == 0)
            send_read();
      end
      repeat ($urandom_range(0, 3)) send_read();
   endtask

   // stray words: ignored mode, out-of-order begins, loose entries and reads
   task automatic send_noise();
      int col_pick;
      case ($urandom_range(0, 3))
         0: send_word(MODE_IGNORED, $urandom_range(0, NODES - 1),
                      $urandom_range(0, NODES - 1));
         1: send_read();
         2: send_word(MODE_BEGIN, $urandom_range(0, NODES - 1),
                      $urandom_range(0, NODES - 1));
         default: begin
            col_pick = $urandom_range(0, NODES - 1);
            // a walk may only start on a node that exists
            if (col_pick < cur_row && !begun[col_pick]) begin
               col_pick = find_begun(int'(cur_row));
               if (col_pick < 0)
                  col_pick = int'(cur_row);
            end
            send_word(MODE_ENTRY, $urandom_range(0, NODES - 1), col_pick);
         end
      endcase
   endtask

   task automatic run_random(int target);
      while (words_sent < target) begin
         if ($urandom_range(0, 99) < 80)
            send_matrix(($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(3, 20));
         else
            repeat ($urandom_range(1, 4)) send_noise();
      end
   endtask

   // stop offering and wait until every awaited word has come back
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tree_sb.pending() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // result side
   // -------------------------------------------------------------------------
   // ready pacing, changed at the falling edge only
   initial begin : rsp_pacer
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            stall    = HOLD_CYCLES;
            holds_done++;
         end else if (stall == 0) begin
            stall = idle_length();
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tree_sb.check_word({rsp_bus.kind, rsp_bus.child, rsp_bus.parent,
                             rsp_bus.has_parent});
   end

   // watchdog: no word moving on either channel for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : main_flow
      tree_sb       = new();
      req_bus.valid = 1'b0;
      req_bus.mode  = MODE_BEGIN;
      req_bus.row   = '0;
      req_bus.col   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening
      send_word(MODE_BEGIN, 0, 1023);     // col ignored on begin
      send_word(MODE_READ, 1023, 0);      // fresh row is a root
      send_word(MODE_ENTRY, 0, 0);        // diagonal entry
      send_word(MODE_BEGIN, 1, 0);
      send_word(MODE_ENTRY, 0, 0);        // first edge 0 -> 1
      send_word(MODE_ENTRY, 0, 0);        // same entry again, nothing new
      send_word(MODE_ENTRY, 0, 1023);     // above the diagonal
      send_word(MODE_BEGIN, 2, 0);
      send_word(MODE_ENTRY, 0, 0);        // two-node walk, edge 1 -> 2
      send_word(MODE_READ, 0, 0);
      send_word(MODE_READ, 1023, 1);
      send_word(MODE_READ, 0, 2);
      send_word(MODE_IGNORED, 1023, 1023);
      send_word(MODE_IGNORED, 0, 0);
      send_word(MODE_BEGIN, 1023, 0);     // top index
      send_word(MODE_ENTRY, 0, 2);        // edge 2 -> 1023
      send_word(MODE_ENTRY, 1023, 0);     // compressed walk, no edge
      send_word(MODE_READ, 0, 1023);      // top row is a root
      send_word(MODE_READ, 1023, 2);
      send_word(MODE_ENTRY, 0, 1023);     // diagonal at the top index
      send_word(MODE_BEGIN, 1000, 0);     // row out of order
      send_word(MODE_ENTRY, 0, 1);        // walk stops at an ancestor above the row
      send_word(MODE_READ, 0, 1000);
      send_word(MODE_READ, 0, 1);
      drain();

      run_random(550);
      drain();

      // long receiver hold-off while reads keep coming, block backs up
      hold_req = 1'b1;
      repeat (40) send_read();
      drain();

      // a stretch with no idling anywhere
      idle_on = 1'b0;
      run_random(850);
      drain();

      idle_on = 1'b1;
      run_random(1300);
      drain();

      // let any final walk finish and catch stray words
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d words: %0d rows begun, %0d entries, %0d parent reads",
               words_sent, tree_sb.rows_begun, tree_sb.entries_seen,
               tree_sb.reads_seen);
      $display("checked %0d tree edges and %0d read replies, %0d long hold-off(s)",
               tree_sb.edges_checked, tree_sb.replies_checked, holds_done);
      if (tree_sb.fail_count == 0 && tree_sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
